[design/fcfs_pkg.sv]
// ----------------------------------------------------------------------------
// fcfs_pkg
// Shared types and codes for the first-come-first-serve scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package fcfs_pkg;

  localparam int DEFAULT_READY_DEPTH = 128;

  typedef enum logic {
    CMD_ARRIVAL = 1'b0,
    CMD_TICK    = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    EV_ENTERED  = 2'd0,
    EV_RUNNING  = 2'd1,
    EV_FINISHED = 2'd2,
    EV_REJECTED = 2'd3
  } event_kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_TICK = 1'b1
  } state_t;

  typedef struct packed {
    command_t    command;
    logic [7:0]  process_id;
    logic [15:0] service_time;
  } req_item_t;

  typedef struct packed {
    event_kind_t event_kind;
    logic [7:0]  event_process;
    logic [31:0] event_time;
    logic        last_event;
  } rsp_item_t;

  typedef struct packed {
    logic [7:0]  process_id;
    logic [15:0] service_time;
  } ready_entry_t;

  // up to two events written per cycle, second only with first
  typedef struct packed {
    logic      en0;
    logic      en1;
    rsp_item_t d0;
    rsp_item_t d1;
  } evq_wr_t;

endpackage

`default_nettype wire

[design/fcfs_process_scheduler_core.sv]
// ----------------------------------------------------------------------------
// fcfs_process_scheduler_core
// Non-preemptive FCFS scheduler: arrivals join a ready queue in memory,
// ticks count down the running process and start the queue head.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | command, process_id, service_time
//   rsp     | out       | rsp_valid/rsp_stall  | event_kind, process, time, last
//
// Arrival: resolved at accept, one event.
// Tick: the head entry is read from the ready memory in the accept
// cycle and used in the next, giving zero, one or two events.
// Reset clears pointers, count, processor state and time; memory is not cleared.
// req_stall is high while a tick is being applied (state ST_TICK) and while the output queue
// has fewer than two free entries.
// ----------------------------------------------------------------------------
`default_nettype none

module fcfs_process_scheduler_core #(
  parameter int READY_DEPTH = fcfs_pkg::DEFAULT_READY_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire fcfs_pkg::req_item_t req,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output fcfs_pkg::rsp_item_t      rsp
);

  localparam int AW = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
  localparam int CW = $clog2(READY_DEPTH + 1);

  fcfs_pkg::state_t state;
  fcfs_pkg::state_t state_next;
  logic [AW-1:0]    head;
  logic [AW-1:0]    head_next;
  logic [AW-1:0]    tail;
  logic [AW-1:0]    tail_next;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [7:0]       running_id;
  logic [7:0]       running_id_next;
  logic [15:0]      remaining;
  logic [15:0]      remaining_next;
  logic             busy;
  logic             busy_next;
  logic [31:0]      time_now;
  logic [31:0]      time_now_next;

  logic                   accept;
  logic                   room2;
  logic                   mem_wr_en;
  fcfs_pkg::ready_entry_t mem_wr_data;
  fcfs_pkg::ready_entry_t mem_rd_data;
  fcfs_pkg::evq_wr_t      evq_wr;

  logic        full;
  logic [15:0] rem_dec;
  logic        fin;
  logic        start;

  assign req_stall = (state != fcfs_pkg::ST_IDLE) || !room2;
  assign accept    = req_valid && !req_stall;
  assign full      = (count == CW'(READY_DEPTH));
  assign rem_dec   = remaining - 16'd1;
  assign fin       = busy && (rem_dec == 16'd0);
  assign start     = (!busy || fin) && (count != '0);

  always_comb begin
    state_next = state;
    case (state)
      fcfs_pkg::ST_IDLE: begin
        if (accept && req.command == fcfs_pkg::CMD_TICK) begin
          state_next = fcfs_pkg::ST_TICK;
        end
      end
      fcfs_pkg::ST_TICK: begin
        state_next = fcfs_pkg::ST_IDLE;
      end
      default: begin
        state_next = fcfs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    running_id_next = running_id;
    remaining_next  = remaining;
    busy_next       = busy;
    time_now_next   = time_now;
    mem_wr_en       = 1'b0;
    mem_wr_data.process_id   = req.process_id;
    mem_wr_data.service_time = (req.service_time == 16'd0) ? 16'd1 : req.service_time;
    evq_wr.en0 = 1'b0;
    evq_wr.en1 = 1'b0;
    evq_wr.d0.event_kind    = fcfs_pkg::EV_ENTERED;
    evq_wr.d0.event_process = req.process_id;
    evq_wr.d0.event_time    = time_now;
    evq_wr.d0.last_event    = 1'b1;
    evq_wr.d1.event_kind    = fcfs_pkg::EV_RUNNING;
    evq_wr.d1.event_process = mem_rd_data.process_id;
    evq_wr.d1.event_time    = time_now;
    evq_wr.d1.last_event    = 1'b1;
    case (state)
      fcfs_pkg::ST_IDLE: begin
        if (accept && req.command == fcfs_pkg::CMD_ARRIVAL) begin
          evq_wr.en0 = 1'b1;
          if (full) begin
            evq_wr.d0.event_kind = fcfs_pkg::EV_REJECTED;
          end else begin
            mem_wr_en  = 1'b1;
            tail_next  = (tail == AW'(READY_DEPTH - 1)) ? '0 : tail + AW'(1);
            count_next = count + CW'(1);
          end
        end
      end
      fcfs_pkg::ST_TICK: begin
        time_now_next = time_now + 32'd1;
        if (busy) begin
          remaining_next = rem_dec;
        end
        if (fin) begin
          busy_next = 1'b0;
        end
        if (start) begin
          head_next       = (head == AW'(READY_DEPTH - 1)) ? '0 : head + AW'(1);
          count_next      = count - CW'(1);
          running_id_next = mem_rd_data.process_id;
          remaining_next  = (mem_rd_data.service_time == 16'd0) ? 16'd1
                                                                 : mem_rd_data.service_time;
          busy_next       = 1'b1;
        end
        if (fin) begin
          evq_wr.en0              = 1'b1;
          evq_wr.d0.event_kind    = fcfs_pkg::EV_FINISHED;
          evq_wr.d0.event_process = running_id;
          evq_wr.d0.last_event    = !start;
          evq_wr.en1              = start;
        end else if (start) begin
          evq_wr.en0              = 1'b1;
          evq_wr.d0.event_kind    = fcfs_pkg::EV_RUNNING;
          evq_wr.d0.event_process = mem_rd_data.process_id;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fcfs_pkg::ST_IDLE;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      running_id <= '0;
      remaining  <= '0;
      busy       <= 1'b0;
      time_now   <= '0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      tail       <= tail_next;
      count      <= count_next;
      running_id <= running_id_next;
      remaining  <= remaining_next;
      busy       <= busy_next;
      time_now   <= time_now_next;
    end
  end

  fcfs_ready_mem #(
    .READY_DEPTH (READY_DEPTH),
    .AW          (AW)
  ) u_ready_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (tail),
    .wr_data (mem_wr_data),
    .rd_addr (head),
    .rd_data (mem_rd_data)
  );

  fcfs_event_queue u_event_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (evq_wr),
    .room2     (room2),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

[design/fcfs_ready_mem.sv]
// ----------------------------------------------------------------------------
// fcfs_ready_mem
// Ready queue storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fcfs_ready_mem #(
  parameter int READY_DEPTH = fcfs_pkg::DEFAULT_READY_DEPTH,
  parameter int AW          = $clog2(READY_DEPTH)
) (
  input  wire logic                   clk,
  input  wire logic                   wr_en,
  input  wire logic [AW-1:0]          wr_addr,
  input  wire fcfs_pkg::ready_entry_t wr_data,
  input  wire logic [AW-1:0]          rd_addr,
  output fcfs_pkg::ready_entry_t      rd_data
);

  fcfs_pkg::ready_entry_t mem [READY_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[design/fcfs_event_queue.sv]
// ----------------------------------------------------------------------------
// fcfs_event_queue
// Four-entry output queue; takes up to two events a cycle, hands out one while rsp_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module fcfs_event_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fcfs_pkg::evq_wr_t wr,
  output logic                   room2,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output fcfs_pkg::rsp_item_t    rsp
);

  fcfs_pkg::rsp_item_t entries [4];
  logic [1:0] rd_ptr;
  logic [1:0] wr_ptr;
  logic [2:0] cnt;
  logic [1:0] rd_ptr_next;
  logic [1:0] wr_ptr_next;
  logic [2:0] cnt_next;
  logic       pop;

  assign rsp_valid = (cnt != 3'd0);
  assign rsp       = entries[rd_ptr];
  assign room2     = (cnt <= 3'd2);
  assign pop       = rsp_valid && !rsp_stall;

  always_comb begin
    rd_ptr_next = rd_ptr + {1'b0, pop};
    wr_ptr_next = wr_ptr + {1'b0, wr.en0} + {1'b0, wr.en1};
    cnt_next    = cnt + {2'b0, wr.en0} + {2'b0, wr.en1} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      cnt    <= '0;
    end else begin
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      cnt    <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en0) begin
      entries[wr_ptr] <= wr.d0;
    end
    if (wr.en1) begin
      entries[wr_ptr + 2'd1] <= wr.d1;
    end
  end

endmodule

`default_nettype wire
